FILE: hdl/bsmm_pkg.sv
// Package for the bit set block: sizes, field types, request codes and
// the priority encoders used by the word scans. No dependencies.
package bsmm_pkg;

    localparam int CAPACITY  = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int VAL_W     = 10;
    localparam int CNT_W     = 11;

    localparam logic [VAL_W-1:0] LIMIT_RESET = VAL_W'(1023);

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [VAL_W-1:0]     val_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WORD_AW-1:0]   waddr_t;
    typedef logic [BIT_AW-1:0]    bidx_t;

    typedef struct packed {
        logic  found;
        bidx_t idx;
    } find_t;

    // lowest set bit
    function automatic find_t find_first(word_t w);
        find_t r;
        r = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (w[j])
            begin
                r.found = 1'b1;
                r.idx   = BIT_AW'(j);
            end
        end
        return r;
    endfunction

    // highest set bit
    function automatic find_t find_last(word_t w);
        find_t r;
        r = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (w[j])
            begin
                r.found = 1'b1;
                r.idx   = BIT_AW'(j);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/bsmm_ifs.sv
// Channel interfaces of the bit set block: request, response and
// configuration write. Depends on bsmm_pkg.
interface bsmm_req_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    bsmm_pkg::val_t      value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface bsmm_rsp_if;
    logic                valid;
    logic                ready;
    logic                ok;
    logic                was_member;
    bsmm_pkg::cnt_t      member_count;
    bsmm_pkg::val_t      lowest_member;
    bsmm_pkg::val_t      highest_member;

    modport source (output valid, ok, was_member, member_count, lowest_member,
                    highest_member, input ready);
    modport sink   (input valid, ok, was_member, member_count, lowest_member,
                    highest_member, output ready);
endinterface

interface bsmm_cfg_if;
    logic                valid;
    logic                ready;
    bsmm_pkg::val_t      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/bsmm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bsmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/bitmap_set_with_min_max.sv
// Top level of the bit set with member count and lowest/highest tracking.
// Depends on bsmm_pkg, bsmm_ifs and bsmm_ram.
//
//  channel | dir | payload                                        | accepted when
//  req     | in  | req_type, value                                | valid & ready
//  rsp     | out | ok, was_member, member_count, lowest/highest   | valid & ready
//  cfg     | in  | data -> value limit                            | valid & ready
//
// An add, a rejected value or a removal that keeps both bounds passes only through ST_IDLE, ST_READ and ST_RESP.
// A removal of the lowest or highest member scans one store word per cycle
// through the single read port, up to the limit's word or down to word 0.
// Per-word valid bits are cleared by reset, so the store reads empty at once.
// The result sits in an output register; a new request is taken while it
// waits, and the next result waits in the response state until it is taken.
module bitmap_set_with_min_max (
    input  logic         clk,
    input  logic         rst_n,
    bsmm_req_if.sink     req,
    bsmm_rsp_if.source   rsp,
    bsmm_cfg_if.sink     cfg
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_READ    = 5'b00010,
        ST_SCAN_LO = 5'b00100,
        ST_SCAN_HI = 5'b01000,
        ST_RESP    = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    bsmm_pkg::cnt_t             count_reg, count_next;
    bsmm_pkg::val_t             lowest_reg, lowest_next;
    bsmm_pkg::val_t             highest_reg, highest_next;
    bsmm_pkg::val_t             limit_reg, limit_next;
    logic [bsmm_pkg::NUM_WORDS-1:0] valid_bits_reg, valid_bits_next;

    logic                       type_reg, type_next;
    bsmm_pkg::val_t             val_reg, val_next;
    logic                       ok_reg, ok_next;
    logic                       was_reg, was_next;
    bsmm_pkg::word_t            cur_word_reg, cur_word_next;
    logic                       first_reg, first_next;
    bsmm_pkg::waddr_t           scan_addr_reg, scan_addr_next;
    logic                       rd_valid_reg;

    logic                       rsp_ok_reg, rsp_ok_next;
    logic                       rsp_was_reg, rsp_was_next;
    bsmm_pkg::cnt_t             rsp_count_reg, rsp_count_next;
    bsmm_pkg::val_t             rsp_low_reg, rsp_low_next;
    bsmm_pkg::val_t             rsp_high_reg, rsp_high_next;

    logic                       ram_wr_en;
    bsmm_pkg::waddr_t           ram_rd_addr;
    bsmm_pkg::word_t            ram_wr_data;
    bsmm_pkg::word_t            ram_rd_data;

    bsmm_pkg::word_t            mem_word;
    bsmm_pkg::word_t            scan_word;
    bsmm_pkg::word_t            sel_mask;
    bsmm_pkg::word_t            up_mask;
    bsmm_pkg::word_t            down_mask;
    bsmm_pkg::waddr_t           val_word;
    bsmm_pkg::bidx_t            val_bit;
    bsmm_pkg::bidx_t            max_bit;
    logic [31:0]                max_word;
    logic                       last_up;
    logic                       val_ok;
    logic                       was_bit;
    bsmm_pkg::find_t            f_lo;
    bsmm_pkg::find_t            f_hi;

    bsmm_ram #(
        .WIDTH (bsmm_pkg::WORD_BITS),
        .DEPTH (bsmm_pkg::NUM_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (val_word),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req.ready          = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.ok             = rsp_ok_reg;
    assign rsp.was_member     = rsp_was_reg;
    assign rsp.member_count   = rsp_count_reg;
    assign rsp.lowest_member  = rsp_low_reg;
    assign rsp.highest_member = rsp_high_reg;

    assign val_word  = bsmm_pkg::WORD_AW'(val_reg >> bsmm_pkg::BIT_AW);
    assign val_bit   = bsmm_pkg::BIT_AW'(val_reg);
    assign max_bit   = bsmm_pkg::BIT_AW'(limit_reg);
    assign max_word  = 32'(limit_reg) >> bsmm_pkg::BIT_AW;
    assign val_ok    = (32'(req.value) <= 32'(limit_reg)) &&
                       (32'(req.value) < 32'(bsmm_pkg::CAPACITY));
    assign mem_word  = rd_valid_reg ? ram_rd_data : '0;
    assign scan_word = first_reg ? cur_word_reg : mem_word;
    assign sel_mask  = bsmm_pkg::word_t'(1) << val_bit;
    assign was_bit   = ok_reg & mem_word[val_bit];
    assign last_up   = (32'(scan_addr_reg) >= max_word) ||
                       (32'(scan_addr_reg) == 32'(bsmm_pkg::NUM_WORDS - 1));

    always_comb
    begin
        up_mask = '1;
        if (scan_addr_reg == val_word)
        begin
            up_mask = ('1 << val_bit) << 1;
        end
        if (32'(scan_addr_reg) == max_word)
        begin
            up_mask = up_mask &
                      (bsmm_pkg::word_t'('1) >> (bsmm_pkg::BIT_AW'(bsmm_pkg::WORD_BITS - 1)
                                                 - max_bit));
        end
        down_mask = '1;
        if (scan_addr_reg == val_word)
        begin
            down_mask = ~(bsmm_pkg::word_t'('1) << val_bit);
        end
    end

    assign f_lo = bsmm_pkg::find_first(scan_word & up_mask);
    assign f_hi = bsmm_pkg::find_last(scan_word & down_mask);

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        count_next      = count_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;
        limit_next      = limit_reg;
        valid_bits_next = valid_bits_reg;
        type_next       = type_reg;
        val_next        = val_reg;
        ok_next         = ok_reg;
        was_next        = was_reg;
        cur_word_next   = cur_word_reg;
        first_next      = first_reg;
        scan_addr_next  = scan_addr_reg;
        rsp_ok_next     = rsp_ok_reg;
        rsp_was_next    = rsp_was_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_low_next    = rsp_low_reg;
        rsp_high_next   = rsp_high_reg;
        ram_wr_en       = 1'b0;
        ram_wr_data     = mem_word;
        ram_rd_addr     = scan_addr_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            limit_next = cfg.data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_addr = bsmm_pkg::WORD_AW'(req.value >> bsmm_pkg::BIT_AW);
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    val_next   = req.value;
                    ok_next    = val_ok;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                was_next   = was_bit;
                state_next = ST_RESP;
                if (ok_reg && type_reg == bsmm_pkg::REQ_ADD && !was_bit)
                begin
                    ram_wr_en                 = 1'b1;
                    ram_wr_data               = mem_word | sel_mask;
                    valid_bits_next[val_word] = 1'b1;
                    count_next                = count_reg + 1'b1;
                    if (count_reg == '0)
                    begin
                        lowest_next  = val_reg;
                        highest_next = val_reg;
                    end
                    else
                    begin
                        if (val_reg < lowest_reg)
                        begin
                            lowest_next = val_reg;
                        end
                        if (val_reg > highest_reg)
                        begin
                            highest_next = val_reg;
                        end
                    end
                end
                else if (ok_reg && type_reg == bsmm_pkg::REQ_REMOVE && was_bit)
                begin
                    ram_wr_en      = 1'b1;
                    ram_wr_data    = mem_word & ~sel_mask;
                    cur_word_next  = mem_word & ~sel_mask;
                    count_next     = count_reg - 1'b1;
                    first_next     = 1'b1;
                    scan_addr_next = val_word;
                    if (count_reg != bsmm_pkg::cnt_t'(1))
                    begin
                        if (val_reg == lowest_reg)
                        begin
                            state_next = ST_SCAN_LO;
                        end
                        else if (val_reg == highest_reg)
                        begin
                            state_next = ST_SCAN_HI;
                        end
                    end
                end
            end

            ST_SCAN_LO:
            begin
                if (f_lo.found || last_up)
                begin
                    if (f_lo.found)
                    begin
                        lowest_next = bsmm_pkg::VAL_W'({scan_addr_reg, f_lo.idx});
                    end
                    first_next     = 1'b1;
                    scan_addr_next = val_word;
                    state_next     = (val_reg == highest_reg) ? ST_SCAN_HI : ST_RESP;
                end
                else
                begin
                    // fetch the next word up
                    first_next     = 1'b0;
                    scan_addr_next = scan_addr_reg + 1'b1;
                    ram_rd_addr    = scan_addr_reg + 1'b1;
                end
            end

            ST_SCAN_HI:
            begin
                if (f_hi.found || scan_addr_reg == '0)
                begin
                    if (f_hi.found)
                    begin
                        highest_next = bsmm_pkg::VAL_W'({scan_addr_reg, f_hi.idx});
                    end
                    state_next = ST_RESP;
                end
                else
                begin
                    first_next     = 1'b0;
                    scan_addr_next = scan_addr_reg - 1'b1;
                    ram_rd_addr    = scan_addr_reg - 1'b1;
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_was_next   = was_reg;
                    rsp_count_next = count_reg;
                    rsp_low_next   = lowest_reg;
                    rsp_high_next  = highest_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            count_reg      <= '0;
            lowest_reg     <= '0;
            highest_reg    <= '0;
            limit_reg      <= bsmm_pkg::LIMIT_RESET;
            valid_bits_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            count_reg      <= count_next;
            lowest_reg     <= lowest_next;
            highest_reg    <= highest_next;
            limit_reg      <= limit_next;
            valid_bits_reg <= valid_bits_next;
            rd_valid_reg   <= valid_bits_reg[ram_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        val_reg       <= val_next;
        ok_reg        <= ok_next;
        was_reg       <= was_next;
        cur_word_reg  <= cur_word_next;
        first_reg     <= first_next;
        scan_addr_reg <= scan_addr_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_was_reg   <= rsp_was_next;
        rsp_count_reg <= rsp_count_next;
        rsp_low_reg   <= rsp_low_next;
        rsp_high_reg  <= rsp_high_next;
    end

endmodule

FILE: hdl/bsmm_checker.sv
// Port-level assertions for the bit set block, bound to the top level.
// Depends on bsmm_pkg and bitmap_set_with_min_max.
module bsmm_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  logic           rsp_ok,
    input  logic           rsp_was_member,
    input  bsmm_pkg::cnt_t rsp_member_count,
    input  bsmm_pkg::val_t rsp_lowest_member,
    input  bsmm_pkg::val_t rsp_highest_member
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
        $stable(rsp_was_member) && $stable(rsp_member_count) &&
        $stable(rsp_lowest_member) && $stable(rsp_highest_member))
        else $error("response changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> !rsp_was_member)
        else $error("rejected request reports membership");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_member_count) <= 32'(bsmm_pkg::CAPACITY))
        else $error("member count above capacity");

endmodule

bind bitmap_set_with_min_max bsmm_checker u_bsmm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_was_member     (rsp.was_member),
    .rsp_member_count   (rsp.member_count),
    .rsp_lowest_member  (rsp.lowest_member),
    .rsp_highest_member (rsp.highest_member)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for bitmap_set_with_min_max: directed add/remove cases, output stall
// and random traffic under several value limit settings, checked against a predictor.
// Depends on bsmm_pkg, bsmm_ifs and the block's RTL.
module testbench;

    typedef struct packed {
        logic           ok;
        logic           was_member;
        bsmm_pkg::cnt_t member_count;
        bsmm_pkg::val_t lowest_member;
        bsmm_pkg::val_t highest_member;
    } set_result_t;

    logic clk;
    logic rst_n;

    bsmm_req_if req_bus ();
    bsmm_rsp_if rsp_bus ();
    bsmm_cfg_if cfg_bus ();

    bitmap_set_with_min_max dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    logic [bsmm_pkg::CAPACITY-1:0] model_bits = '0;
    bsmm_pkg::cnt_t                model_count = '0;
    bsmm_pkg::val_t                model_low = '0;
    bsmm_pkg::val_t                model_high = '0;
    bsmm_pkg::val_t                model_max = bsmm_pkg::LIMIT_RESET;

    set_result_t pending_set_results[$];
    set_result_t want;
    int          mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_left = 0;
    int          member_target = 8;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic set_result_t predict_set_update(logic rt, bsmm_pkg::val_t v);
        set_result_t r;
        r = '0;
        if (v <= model_max)
        begin
            r.ok = 1'b1;
            r.was_member = model_bits[v];
            if (rt == bsmm_pkg::REQ_ADD)
            begin
                if (!r.was_member)
                begin
                    model_bits[v] = 1'b1;
                    model_count = model_count + 1'b1;
                    if (model_count == 1)
                    begin
                        model_low = v;
                        model_high = v;
                    end
                    else
                    begin
                        if (v < model_low)
                            model_low = v;
                        if (v > model_high)
                            model_high = v;
                    end
                end
            end
            else if (r.was_member)
            begin
                model_bits[v] = 1'b0;
                model_count = model_count - 1'b1;
                if (model_count > 0)
                begin
                    if (v == model_low)
                    begin
                        for (int i = int'(v) + 1; i <= int'(model_max); i++)
                        begin
                            if (model_bits[i])
                            begin
                                model_low = bsmm_pkg::val_t'(i);
                                break;
                            end
                        end
                    end
                    if (v == model_high)
                    begin
                        for (int i = int'(v) - 1; i >= 0; i--)
                        begin
                            if (model_bits[i])
                            begin
                                model_high = bsmm_pkg::val_t'(i);
                                break;
                            end
                        end
                    end
                end
            end
        end
        r.member_count = model_count;
        r.lowest_member = model_low;
        r.highest_member = model_high;
        return r;
    endfunction

    // response sink; a hold-off keeps ready low while hold_left counts down
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_bus.ready = 1'b0;
            end
            else
                rsp_bus.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_set_results.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_set_results.pop_front();
                check_field("ok", int'(want.ok), int'(rsp_bus.ok));
                check_field("was_member", int'(want.was_member),
                            int'(rsp_bus.was_member));
                check_field("member_count", int'(want.member_count),
                            int'(rsp_bus.member_count));
                check_field("lowest_member", int'(want.lowest_member),
                            int'(rsp_bus.lowest_member));
                check_field("highest_member", int'(want.highest_member),
                            int'(rsp_bus.highest_member));
            end
        end
    end

    task automatic send_request(logic rt, bsmm_pkg::val_t v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            req_bus.valid = 1'b0;
        end
        @(negedge clk);
        req_bus.valid = 1'b1;
        req_bus.req_type = rt;
        req_bus.value = v;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pending_set_results.push_back(predict_set_update(rt, v));
    endtask

    task automatic drain_requests();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (pending_set_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(bsmm_pkg::val_t m);
        drain_requests();
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.data = m;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        model_max = m;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // mostly well-formed traffic: keep the set near a target size and
    // remove the current bounds often so the scans run
    task automatic next_random_request();
        logic           rt;
        bsmm_pkg::val_t v;
        int             pick;
        if ($urandom_range(49) == 0)
            member_target = ($urandom_range(7) == 0) ? $urandom_range(400, 100)
                                                     : $urandom_range(24, 1);
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            rt = 1'($urandom);
            v = bsmm_pkg::val_t'($urandom);
        end
        else if (pick < ((model_count < member_target) ? 68 : 35))
        begin
            rt = bsmm_pkg::REQ_ADD;
            if (model_max != 10'h3FF && $urandom_range(9) == 0)
                v = bsmm_pkg::val_t'($urandom_range(1023, int'(model_max) + 1));
            else
                v = bsmm_pkg::val_t'($urandom_range(int'(model_max), 0));
        end
        else
        begin
            rt = bsmm_pkg::REQ_REMOVE;
            pick = $urandom_range(9);
            if (pick < 4)
                v = model_low;
            else if (pick < 8)
                v = model_high;
            else
                v = bsmm_pkg::val_t'($urandom_range(int'(model_max), 0));
        end
        send_request(rt, v);
    endtask

    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_request(bsmm_pkg::REQ_REMOVE, 10'd0);
        send_request(bsmm_pkg::REQ_ADD, 10'd0);
        send_request(bsmm_pkg::REQ_ADD, 10'd1023);
        send_request(bsmm_pkg::REQ_ADD, 10'd0);
        send_request(bsmm_pkg::REQ_ADD, 10'd512);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd0);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd1023);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd512);
        send_request(bsmm_pkg::REQ_ADD, 10'd700);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd700);
        send_request(bsmm_pkg::REQ_ADD, 10'd10);
        send_request(bsmm_pkg::REQ_ADD, 10'd90);
        // members above the new limit: rejected, and the upward scan finds nothing
        write_limit(10'd50);
        send_request(bsmm_pkg::REQ_ADD, 10'd51);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd90);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd10);
        send_request(bsmm_pkg::REQ_ADD, 10'd50);
        write_limit(10'd0);
        send_request(bsmm_pkg::REQ_ADD, 10'd0);
        send_request(bsmm_pkg::REQ_ADD, 10'd1);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd0);
        write_limit(10'd1023);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd90);
        send_request(bsmm_pkg::REQ_REMOVE, 10'd50);
        drain_requests();
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left = 400;
        repeat (30) next_random_request();
        drain_requests();
        repeat (10) next_random_request();
        drain_requests();
    endtask

    task automatic test_random_traffic();
        bsmm_pkg::val_t max_plan[9] = '{10'd1023, 10'd0, 10'd600, 10'd33, 10'd1023,
                                        10'd200, 10'd1023, 10'd511, 10'd1023};
        int             tx_plan[3] = '{34, 87, 0};
        int             rx_plan[3] = '{87, 34, 0};
        for (int p = 0; p < 3; p++)
        begin
            tx_idle_pct = tx_plan[p];
            rx_idle_pct = rx_plan[p];
            for (int c = 0; c < 3; c++)
            begin
                write_limit(max_plan[p * 3 + c]);
                repeat ((max_plan[p * 3 + c] == 0) ? 40 : 105) next_random_request();
            end
        end
        drain_requests();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = bsmm_pkg::REQ_ADD;
        req_bus.value = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_output_stall();
        test_random_traffic();

        drain_requests();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_set_results.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
